### rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the delimiter string splitter.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int unsigned SYM_W     = 8;
    localparam int unsigned DLEN_W    = 4;
    localparam int unsigned REG_BYTES = 8;
    localparam int unsigned DBYTES_W  = REG_BYTES * SYM_W;

    typedef enum logic [0:0] {
        CFG_DELIM_LENGTH = 1'b0,
        CFG_DELIM_BYTES  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [SYM_W-1:0] token_symbol;
        logic             token_end;
    } t_out_item;

    typedef struct packed {
        logic                valid;
        t_cfg_idx            index;
        logic [DBYTES_W-1:0] data;
    } t_cfg_wr;

endpackage

### rtl/delimiter_string_splitter.sv
// ----------------------------------------------------------------------------
// delimiter_string_splitter
// Splits a byte stream into tokens at a configured delimiter of 0..8 bytes.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+---------------------------
//  in       | input     | i_in_valid / o_in_ready     | i_in_item  (symbol, eot)
//  out      | output    | o_out_valid / i_out_ready   | o_out_item (byte, end)
//  cfg      | input     | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
//  One byte is taken per cycle while the output does not stall and no flush runs;
//  a request waits in the input register, its result (if any) in the result register.
//  A byte with end-of-text starts a flush that releases each pending window byte
//  and then ends the token, at most one result per cycle while the result register
//  is free; no input is taken meanwhile. Reset (i_rst_n low, synchronous) empties
//  the window and clears config. A stall on the output holds the next request in
//  the input register; an empty input register still takes one request while the
//  result waits. Config is always ready.
// ----------------------------------------------------------------------------
module delimiter_string_splitter #(
    parameter int unsigned MAX_DELIM = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // byte stream
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  dss_pkg::t_in_item               i_in_item,
    // token stream
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output dss_pkg::t_out_item              o_out_item,
    // config writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  dss_pkg::t_cfg_idx               i_cfg_index,
    input  logic [dss_pkg::DBYTES_W-1:0]    i_cfg_data
);
    import dss_pkg::*;

    logic      in_vld;
    t_in_item  in_item;
    logic      take;
    logic      slot_free;
    logic      res_valid;
    t_out_item res_item;
    t_cfg_wr   cfg_wr;

    // the user must issue writes only while the block is idle (not enforced); never back-pressured
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = '{valid: i_cfg_valid, index: i_cfg_index, data: i_cfg_data};

    // input register: decouples upstream from the step logic
    dss_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (in_vld),
        .i_take  (take),
        .o_item  (in_item)
    );

    // window compare, token byte hold-back and end-of-text flush
    dss_core #(
        .MAX_DELIM (MAX_DELIM)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_wr),
        .i_in_valid  (in_vld),
        .i_in_item   (in_item),
        .o_take      (take),
        .i_slot_free (slot_free),
        .o_res_valid (res_valid),
        .o_res_item  (res_item)
    );

    // result register toward the token stream
    dss_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res_item  (res_item),
        .o_slot_free (slot_free),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_item      (o_out_item)
    );

endmodule

### rtl/dss_in_stage.sv
// ----------------------------------------------------------------------------
// dss_in_stage
// Input register: holds one accepted request until the core takes it.
// ----------------------------------------------------------------------------
module dss_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dss_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_take,
    output dss_pkg::t_in_item o_item
);
    import dss_pkg::*;

    logic     r_vld;
    t_in_item r_item;

    assign o_ready = !r_vld || i_take;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

### rtl/dss_out_reg.sv
// ----------------------------------------------------------------------------
// dss_out_reg
// Result register toward the output channel.
// ----------------------------------------------------------------------------
module dss_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_valid,
    input  dss_pkg::t_out_item i_res_item,
    output logic               o_slot_free,
    output logic               o_valid,
    input  logic               i_ready,
    output dss_pkg::t_out_item o_item
);
    import dss_pkg::*;

    logic      r_vld;
    t_out_item r_item;

    assign o_slot_free = !r_vld || i_ready;
    assign o_valid     = r_vld;
    assign o_item      = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_res_valid) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_item <= i_res_item;
        end
    end

endmodule

### rtl/dss_core.sv
// ----------------------------------------------------------------------------
// dss_core
// Match window, held byte, config registers and end-of-text flush.
// ----------------------------------------------------------------------------
module dss_core #(
    parameter int unsigned MAX_DELIM = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dss_pkg::t_cfg_wr   i_cfg,
    input  logic               i_in_valid,
    input  dss_pkg::t_in_item  i_in_item,
    output logic               o_take,
    input  logic               i_slot_free,
    output logic               o_res_valid,
    output dss_pkg::t_out_item o_res_item
);
    import dss_pkg::*;

    localparam int unsigned WIN_DEPTH = (MAX_DELIM < REG_BYTES) ? MAX_DELIM : REG_BYTES;
    localparam int unsigned FILL_W    = $clog2(WIN_DEPTH + 1);

    logic [SYM_W-1:0]    r_win [WIN_DEPTH];
    logic [SYM_W-1:0]    n_win [WIN_DEPTH];
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [SYM_W-1:0]    r_held, n_held;
    logic                r_held_vld, n_held_vld;
    logic                r_flush, n_flush;
    logic [DLEN_W-1:0]   r_dlen, n_dlen;
    logic [DBYTES_W-1:0] r_dbytes, n_dbytes;

    logic [FILL_W-1:0]   len_act;
    logic [FILL_W-1:0]   fill_c;
    logic [FILL_W-1:0]   fill_p;
    logic [SYM_W-1:0]    win_w [WIN_DEPTH];
    logic [SYM_W-1:0]    win_s [WIN_DEPTH];
    logic [SYM_W-1:0]    win_f [WIN_DEPTH];
    logic [WIN_DEPTH-1:0] lane_ok;
    logic                hit;
    logic                full;

    // saturate length to what the window holds
    assign len_act = (r_dlen > DLEN_W'(WIN_DEPTH)) ? FILL_W'(WIN_DEPTH)
                                                   : FILL_W'(r_dlen);
    assign o_take  = i_in_valid && !r_flush && i_slot_free;

    assign fill_c = (r_fill >= len_act) ? (len_act - FILL_W'(1)) : r_fill;
    assign fill_p = fill_c + FILL_W'(1);
    assign full   = (fill_p == len_act);

    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            win_w[i]   = (fill_c == FILL_W'(i)) ? i_in_item.symbol : r_win[i];
            lane_ok[i] = (FILL_W'(i) >= len_act) ||
                         (win_w[i] == r_dbytes[SYM_W*i +: SYM_W]);
        end
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            win_s[i] = win_w[i+1];
            win_f[i] = r_win[i+1];
        end
        win_s[WIN_DEPTH-1] = win_w[WIN_DEPTH-1];
        win_f[WIN_DEPTH-1] = r_win[WIN_DEPTH-1];
    end

    assign hit = &lane_ok;

    always_comb begin
        n_win       = r_win;
        n_fill      = r_fill;
        n_held      = r_held;
        n_held_vld  = r_held_vld;
        n_flush     = r_flush;
        n_dlen      = r_dlen;
        n_dbytes    = r_dbytes;
        o_res_valid = 1'b0;
        o_res_item  = '{token_symbol: r_held, token_end: 1'b0};

        if (r_flush) begin
            if (i_slot_free) begin
                if (r_fill != '0) begin
                    // pending byte becomes a token byte
                    o_res_valid = r_held_vld;
                    n_held      = r_win[0];
                    n_held_vld  = 1'b1;
                    n_win       = win_f;
                    n_fill      = r_fill - FILL_W'(1);
                end else begin
                    o_res_valid          = r_held_vld;
                    o_res_item.token_end = 1'b1;
                    n_held_vld           = 1'b0;
                    n_flush              = 1'b0;
                end
            end
        end else if (o_take && (len_act != '0)) begin
            if (!full) begin
                n_win  = win_w;
                n_fill = fill_p;
            end else if (hit) begin
                o_res_valid          = r_held_vld;
                o_res_item.token_end = 1'b1;
                n_held_vld           = 1'b0;
                n_fill               = '0;
            end else begin
                o_res_valid = r_held_vld;
                n_held      = win_w[0];
                n_held_vld  = 1'b1;
                n_win       = win_s;
                n_fill      = len_act - FILL_W'(1);
            end
            n_flush = i_in_item.end_of_text;
        end

        // the user must send config writes only while idle; this block does not enforce it
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DELIM_LENGTH: begin
                    n_dlen     = i_cfg.data[DLEN_W-1:0];
                    n_fill     = '0;
                    n_held_vld = 1'b0;
                end
                CFG_DELIM_BYTES: begin
                    n_dbytes = i_cfg.data;
                end
                default: begin
                    n_dbytes = r_dbytes;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_held_vld <= 1'b0;
            r_flush    <= 1'b0;
            r_dlen     <= '0;
            r_dbytes   <= '0;
        end else begin
            r_fill     <= n_fill;
            r_held_vld <= n_held_vld;
            r_flush    <= n_flush;
            r_dlen     <= n_dlen;
            r_dbytes   <= n_dbytes;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win  <= n_win;
        r_held <= n_held;
    end

    a_fill_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) || (r_fill < len_act))
        else $error("window fill not below delimiter length");

    a_res_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_slot_free)
        else $error("result issued into a full result register");

    a_end_clears_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res_item.token_end) |=> !r_held_vld)
        else $error("held byte still valid after token end");

    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flush && (r_fill == '0) && i_slot_free) |=> !r_flush)
        else $error("flush did not terminate");

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the delimiter string splitter: directed requests, then random texts
// built around the delimiter, each output token checked against a model or a typed row.
// ----------------------------------------------------------------------------
module testbench;

    import dss_pkg::*;

    localparam int unsigned MAX_DELIM      = 8;
    // idle cycles waited after the last token before a config write or the end
    localparam int          DRAIN_GAP      = 20;
    // cycles with no handshake on any channel before the run is declared hung
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          TEXT_QUOTA     = 28;
    localparam int          SETTINGS_PER_PHASE = 4;

    // kinds of rows in the directed plan
    typedef enum logic [1:0] {
        ROW_CFG,    // register write
        ROW_SYM,    // byte, tokens come from the model
        ROW_CHK     // byte, tokens typed into the row
    } t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        t_cfg_idx            cfg_idx;
        logic [DBYTES_W-1:0] cfg_data;
        t_in_item            item;
        logic                exp_any;   // ROW_CHK: one token expected, else none
        t_out_item           exp_tok;
    } t_plan_row;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out_item;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    t_cfg_idx            i_cfg_index = CFG_DELIM_LENGTH;
    logic [DBYTES_W-1:0] i_cfg_data  = '0;

    // idle percentages of the two stream sides, changed per phase
    int send_idle_pct = 13;
    int recv_idle_pct = 67;

    int mismatch_cnt = 0;
    int stall_cycles = 0;

    // ------------------------------------------------------------------------
    // Splitter model state (mirrors the block right after reset)
    // ------------------------------------------------------------------------
    logic [SYM_W-1:0]    pend_bytes [MAX_DELIM];  // bytes that may still start a match
    int                  pend_cnt  = 0;
    logic [SYM_W-1:0]    hold_sym  = '0;          // last token byte, kept back for end mark
    logic                hold_ok   = 1'b0;
    logic [DLEN_W-1:0]   cfg_len   = '0;
    logic [DBYTES_W-1:0] cfg_delim = '0;

    t_out_item step_tokens[$];      // tokens caused by the current request
    t_out_item token_expect_q[$];   // tokens still owed by the block, oldest first
    t_plan_row plan[$];

    delimiter_string_splitter #(
        .MAX_DELIM (MAX_DELIM)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Model of the splitter
    // ------------------------------------------------------------------------

    // delimiter length in use: the register saturates at the window depth
    // and at the bytes the delimiter register can hold
    function automatic int live_length();
        int len;
        len = cfg_len;
        if (len > MAX_DELIM) len = MAX_DELIM;
        if (len > REG_BYTES) len = REG_BYTES;
        return len;
    endfunction

    function automatic logic [SYM_W-1:0] delim_byte(input int k);
        return cfg_delim[SYM_W*k +: SYM_W];
    endfunction

    function automatic void emit_token(input logic [SYM_W-1:0] b, input logic last);
        t_out_item t;
        t.token_symbol = b;
        t.token_end    = last;
        step_tokens.push_back(t);
    endfunction

    // a confirmed token byte releases the one held before it
    function automatic void take_token_byte(input logic [SYM_W-1:0] b);
        if (hold_ok) emit_token(hold_sym, 1'b0);
        hold_sym = b;
        hold_ok  = 1'b1;
    endfunction

    // an empty token leaves nothing behind
    function automatic void end_token();
        if (hold_ok) emit_token(hold_sym, 1'b1);
        hold_ok = 1'b0;
    endfunction

    function automatic void split_symbol(input t_in_item it);
        int  len;
        bit  hit;
        step_tokens.delete();
        len = live_length();
        if (len == 0) return;

        if (pend_cnt >= len) pend_cnt = len - 1;
        pend_bytes[pend_cnt] = it.symbol;
        pend_cnt++;

        if (pend_cnt == len) begin
            hit = 1'b1;
            for (int i = 0; i < len; i++) begin
                if (pend_bytes[i] != delim_byte(i)) hit = 1'b0;
            end
            if (hit) begin
                end_token();
                pend_cnt = 0;
            end else begin
                // oldest byte can no longer start a match
                take_token_byte(pend_bytes[0]);
                for (int i = 1; i < len; i++) pend_bytes[i-1] = pend_bytes[i];
                pend_cnt--;
            end
        end

        if (it.end_of_text) begin
            for (int i = 0; i < pend_cnt; i++) take_token_byte(pend_bytes[i]);
            pend_cnt = 0;
            end_token();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Directed plan row builders
    // ------------------------------------------------------------------------
    function automatic t_plan_row cfg_row(input t_cfg_idx idx,
                                          input logic [DBYTES_W-1:0] data);
        t_plan_row r;
        r          = '0;
        r.kind     = ROW_CFG;
        r.cfg_idx  = idx;
        r.cfg_data = data;
        return r;
    endfunction

    function automatic t_plan_row sym_row(input logic [SYM_W-1:0] sym, input logic eot);
        t_plan_row r;
        r                  = '0;
        r.kind             = ROW_SYM;
        r.item.symbol      = sym;
        r.item.end_of_text = eot;
        return r;
    endfunction

    function automatic t_plan_row chk_row(input logic [SYM_W-1:0] sym, input logic eot,
                                          input logic any, input logic [SYM_W-1:0] tsym,
                                          input logic tend);
        t_plan_row r;
        r                      = sym_row(sym, eot);
        r.kind                 = ROW_CHK;
        r.exp_any              = any;
        r.exp_tok.token_symbol = tsym;
        r.exp_tok.token_end    = tend;
        return r;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("%s", msg);
    endfunction

    // ------------------------------------------------------------------------
    // Channel tasks; inputs move at the falling edge only
    // ------------------------------------------------------------------------

    // Send one byte request. On acceptance the model runs, and the tokens owed
    // come either from the model or from the typed row.
    task automatic push_symbol(input t_in_item it, input bit typed,
                               input logic exp_any, input t_out_item exp_tok);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item  = it;
        do @(posedge i_clk); while (!o_in_ready);
        split_symbol(it);
        if (typed) begin
            if (exp_any) token_expect_q.push_back(exp_tok);
        end else begin
            foreach (step_tokens[j]) token_expect_q.push_back(step_tokens[j]);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [DBYTES_W-1:0] data);
        @(negedge i_clk);
        i_in_valid  = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_DELIM_LENGTH) begin
            // new length starts a fresh text
            cfg_len  = data[DLEN_W-1:0];
            pend_cnt = 0;
            hold_ok  = 1'b0;
        end else begin
            // pending bytes stay, later compares see the new delimiter
            cfg_delim = data;
        end
    endtask

    // Wait for every owed token, then idle long enough for the input register
    // and any flush to empty before anything else happens.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid  = 1'b0;
        i_cfg_valid = 1'b0;
        while (token_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Random settings and texts
    // ------------------------------------------------------------------------
    task automatic pick_setting(input int phase, input int sub);
        logic [DLEN_W-1:0]   len;
        logic [DBYTES_W-1:0] d;
        logic [SYM_W-1:0]    a;
        logic [SYM_W-1:0]    b;
        int                  r;
        // first settings of each phase hit the length extremes
        if (sub == 0)
            len = (phase == 0) ? 4'd8 : (phase == 1) ? 4'd1 : 4'd15;
        else if (phase == 0 && sub == 1)
            len = 4'd0;
        else begin
            r = $urandom_range(99);
            if (r < 80)      len = DLEN_W'($urandom_range(1, 8));
            else if (r < 90) len = DLEN_W'($urandom_range(9, 15));
            else             len = 4'd0;
        end

        // delimiter shapes: random, one repeated byte (self-overlapping),
        // two-letter alphabet, all zeros or all ones
        a = SYM_W'($urandom_range(0, 255));
        b = SYM_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: begin
                d = {$urandom, $urandom};
            end
            1: begin
                d = {REG_BYTES{a}};
            end
            2: begin
                for (int k = 0; k < REG_BYTES; k++)
                    d[SYM_W*k +: SYM_W] = $urandom_range(0, 1) ? a : b;
            end
            default: begin
                d = $urandom_range(0, 1) ? '1 : '0;
            end
        endcase

        // sometimes only the delimiter changes, keeping the pending text
        if (sub == 0 || $urandom_range(99) >= 25) begin
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_DELIM_BYTES, d);
                write_reg(CFG_DELIM_LENGTH, DBYTES_W'(len));
            end else begin
                write_reg(CFG_DELIM_LENGTH, DBYTES_W'(len));
                write_reg(CFG_DELIM_BYTES, d);
            end
        end else begin
            write_reg(CFG_DELIM_BYTES, d);
        end
    endtask

    // Texts are mostly delimiters, partial delimiters and near-miss bytes, so
    // the window walks through every fill level; a tenth are pure noise.
    task automatic run_texts(input int quota);
        logic [SYM_W-1:0] text[$];
        logic [SYM_W-1:0] b;
        t_in_item         it;
        int               sent;
        int               len;
        int               r;
        int               n;
        int               k;
        bit               eot_last;
        sent = 0;
        while (sent < quota) begin
            len = live_length();
            text.delete();
            if ($urandom_range(99) < 10) begin
                n = $urandom_range(1, 12);
                repeat (n) text.push_back(SYM_W'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    r = (len == 0) ? 99 : $urandom_range(99);
                    if (r < 35) begin
                        for (k = 0; k < len; k++) text.push_back(delim_byte(k));
                    end else if (r < 50 && len > 1) begin
                        n = $urandom_range(1, len - 1);
                        for (k = 0; k < n; k++) text.push_back(delim_byte(k));
                    end else if (r < 85) begin
                        repeat ($urandom_range(1, 3)) begin
                            b = delim_byte($urandom_range(0, len - 1));
                            if ($urandom_range(0, 3) == 0) b = b + 8'd1;
                            text.push_back(b);
                        end
                    end else begin
                        text.push_back(SYM_W'($urandom_range(0, 255)));
                    end
                end
            end
            // some texts run on into the next one without an end mark
            eot_last = ($urandom_range(99) < 85);
            foreach (text[j]) begin
                it.symbol      = text[j];
                it.end_of_text = (j == text.size() - 1) && eot_last;
                push_symbol(it, 1'b0, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Token sink: ready toggles at the falling edge
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge i_clk);
            i_out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Token checker, sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : token_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (token_expect_q.size() == 0) begin
                note_mismatch($sformatf("unexpected token: got sym %02h end %0d",
                                        o_out_item.token_symbol, o_out_item.token_end));
            end else begin
                want = token_expect_q.pop_front();
                if (o_out_item.token_symbol !== want.token_symbol ||
                    o_out_item.token_end !== want.token_end) begin
                    note_mismatch($sformatf(
                        "token mismatch: expected sym %02h end %0d, got sym %02h end %0d",
                        want.token_symbol, want.token_end,
                        o_out_item.token_symbol, o_out_item.token_end));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any handshake on any channel counts as progress
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        // zero length after reset: the block stays silent
        plan.push_back(chk_row("A", 1'b1, 1'b0, 8'h00, 1'b0));
        // single-byte comma delimiter
        plan.push_back(cfg_row(CFG_DELIM_LENGTH, 64'd1));
        plan.push_back(cfg_row(CFG_DELIM_BYTES, 64'h2c));
        plan.push_back(chk_row("a", 1'b0, 1'b0, 8'h00, 1'b0));   // held back
        plan.push_back(chk_row(",", 1'b0, 1'b1, "a", 1'b1));     // closes token
        plan.push_back(chk_row(",", 1'b0, 1'b0, 8'h00, 1'b0));   // empty token dropped
        plan.push_back(chk_row(8'hff, 1'b1, 1'b1, 8'hff, 1'b1)); // byte extremes
        plan.push_back(chk_row(8'h00, 1'b1, 1'b1, 8'h00, 1'b1));
        // length above the window depth saturates; all-ones delimiter;
        // end of text flushes a partly filled window
        plan.push_back(cfg_row(CFG_DELIM_LENGTH, 64'd15));
        plan.push_back(cfg_row(CFG_DELIM_BYTES, '1));
        plan.push_back(sym_row(8'hff, 1'b0));
        plan.push_back(sym_row(8'hff, 1'b0));
        plan.push_back(sym_row(8'h01, 1'b1));
        // "AA" against "AAAb": leftmost match, no overlap
        plan.push_back(cfg_row(CFG_DELIM_LENGTH, 64'd2));
        plan.push_back(cfg_row(CFG_DELIM_BYTES, 64'h4141));
        plan.push_back(sym_row("A", 1'b0));
        plan.push_back(sym_row("A", 1'b0));
        plan.push_back(sym_row("A", 1'b0));
        plan.push_back(sym_row("b", 1'b1));
        // delimiter rewritten with "x" pending; text ends in the delimiter
        plan.push_back(sym_row("q", 1'b0));
        plan.push_back(sym_row("x", 1'b0));
        plan.push_back(cfg_row(CFG_DELIM_BYTES, 64'h7978));
        plan.push_back(chk_row("y", 1'b1, 1'b1, "q", 1'b1));
        // length rewritten drops the pending "m"
        plan.push_back(sym_row("m", 1'b0));
        plan.push_back(cfg_row(CFG_DELIM_LENGTH, 64'd1));
        plan.push_back(chk_row("n", 1'b1, 1'b1, "n", 1'b1));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_CFG: begin
                    settle();
                    write_reg(plan[i].cfg_idx, plan[i].cfg_data);
                end
                ROW_CHK: begin
                    push_symbol(plan[i].item, 1'b1, plan[i].exp_any, plan[i].exp_tok);
                end
                default: begin
                    push_symbol(plan[i].item, 1'b0, 1'b0, '0);
                end
            endcase
        end

        // random phases: sender-light/sink-heavy, the reverse, then no idling
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 67 : 0;
            recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 13 : 0;
            for (int sub = 0; sub < SETTINGS_PER_PHASE; sub++) begin
                settle();
                pick_setting(phase, sub);
                // a disabled block only gets a few bytes
                run_texts((live_length() == 0) ? 6 : TEXT_QUOTA);
            end
        end

        settle();
        if (mismatch_cnt == 0 && token_expect_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
